>>> hdl/kms_pkg.sv
// Shared types and codes for the KMP stream matcher.
// Depends on nothing; every other file of the block imports it.
package kms_pkg;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MATCH     = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LOOK = 1'b1
  } ctrl_state_t;

  localparam int unsigned POS_W = 32;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   match_position;
  } result_t;

endpackage

>>> hdl/kmp_stream_matcher.sv
// Top level of the KMP stream matcher: stream ports and result register.
// Instantiates kms_ctrl and kms_mem; uses kms_pkg.
//
// Streaming Knuth-Morris-Pratt search. Send the pattern first as requests with
// operation 0, one byte each (first restarts the pattern), then the text with
// operation 1 (first restarts the search, last marks the final text byte).
// Every request yields exactly one result: status 0 for an accepted byte with
// no decision, 1 with the start offset of the first match, 2 when the text ends
// unmatched, 3 for a pattern byte beyond MAX_PATTERN (dropped). After a match
// or an unmatched end, further text bytes answer 0 until a new first or a new
// pattern byte. An empty pattern matches at the current offset at once.
// A request is accepted in the idle state, then the lookup state checks one memory
// read and repeats once per failure link followed; the pattern and failure RAMs are
// read once per cycle at one address each, so that single read port sets the rate.
// Over a text the links followed never exceed the bytes consumed. A full result
// register that is not drained holds the sequencer in its lookup state. No clearing
// pass follows reset: table entries are read only once written.
module kmp_stream_matcher import kms_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] operation, [1] first
  input  logic        in_tlast,   // last byte of the text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] match_position
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned AW = $clog2(MAX_PATTERN);

  logic          req_fire;
  logic          out_room;
  logic          res_fire;
  result_t       res;

  logic          wr_en;
  logic [AW-1:0] wr_idx;
  logic [7:0]    wr_pat;
  logic [AW-1:0] wr_fail;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rd_fidx;
  logic [7:0]    rd_pat;
  logic [AW-1:0] rd_fail;

  logic          out_tvalid_r;
  result_t       out_res_r;

  // take a request whenever the sequencer is idle, even with a result waiting
  assign req_fire = in_tvalid && in_tready;
  // result register frees up in the same cycle it is drained
  assign out_room = !out_tvalid_r || out_tready;

  kms_ctrl #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_fire  (req_fire),
    .req_op    (op_t'(in_tuser[0])),
    .req_byte  (in_tdata),
    .req_first (in_tuser[1]),
    .req_last  (in_tlast),
    .req_ready (in_tready),
    .out_room  (out_room),
    .res_fire  (res_fire),
    .res       (res),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_pat    (wr_pat),
    .wr_fail   (wr_fail),
    .rd_idx    (rd_idx),
    .rd_fidx   (rd_fidx),
    .rd_pat    (rd_pat),
    .rd_fail   (rd_fail)
  );

  kms_mem #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_pat  (wr_pat),
    .wr_fail (wr_fail),
    .rd_idx  (rd_idx),
    .rd_fidx (rd_fidx),
    .rd_pat  (rd_pat),
    .rd_fail (rd_fail)
  );

  // hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_res_r.match_position;
  assign out_tuser  = out_res_r.status;

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten");

  // a result only leaves the sequencer after a request came in
  a_result_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> !in_tready)
    else $error("result produced while idle");

  // match offsets only travel with a match status
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_fire && res.status != ST_MATCH) |-> (res.match_position == '0))
    else $error("offset set without a match");

endmodule

>>> hdl/kms_mem.sv
// Pattern byte and failure link storage for the KMP stream matcher.
// Two synchronous RAMs, one write and one registered read each; uses kms_pkg.
module kms_mem import kms_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 512
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_PATTERN)-1:0] wr_idx,
  input  logic [7:0]                     wr_pat,
  input  logic [$clog2(MAX_PATTERN)-1:0] wr_fail,
  input  logic [$clog2(MAX_PATTERN)-1:0] rd_idx,
  input  logic [$clog2(MAX_PATTERN)-1:0] rd_fidx,
  output logic [7:0]                     rd_pat,
  output logic [$clog2(MAX_PATTERN)-1:0] rd_fail
);

  localparam int unsigned AW = $clog2(MAX_PATTERN);

  logic [7:0]    pat_mem  [MAX_PATTERN];
  logic [AW-1:0] fail_mem [MAX_PATTERN];

  // pattern byte k and failure link k-1 are read together
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_mem[wr_idx]  <= wr_pat;
      fail_mem[wr_idx] <= wr_fail;
    end
    rd_pat  <= pat_mem[rd_idx];
    rd_fail <= fail_mem[rd_fidx];
  end

endmodule

>>> hdl/kms_ctrl.sv
// Sequencer of the KMP stream matcher: prefix table build, text search, counters.
// Walks failure links one per cycle through kms_mem; uses kms_pkg.
module kms_ctrl import kms_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_fire,
  input  op_t                            req_op,
  input  logic [7:0]                     req_byte,
  input  logic                           req_first,
  input  logic                           req_last,
  output logic                           req_ready,
  input  logic                           out_room,
  output logic                           res_fire,
  output result_t                        res,
  output logic                           wr_en,
  output logic [$clog2(MAX_PATTERN)-1:0] wr_idx,
  output logic [7:0]                     wr_pat,
  output logic [$clog2(MAX_PATTERN)-1:0] wr_fail,
  output logic [$clog2(MAX_PATTERN)-1:0] rd_idx,
  output logic [$clog2(MAX_PATTERN)-1:0] rd_fidx,
  input  logic [7:0]                     rd_pat,
  input  logic [$clog2(MAX_PATTERN)-1:0] rd_fail
);

  localparam int unsigned AW = $clog2(MAX_PATTERN);
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

  ctrl_state_t       state_r, state_nxt;
  op_t               op_r;
  logic [7:0]        byte_r;
  logic              last_r;
  logic [LW-1:0]     k_r, k_nxt;
  logic [LW-1:0]     plen_r, plen_nxt;
  logic [LW-1:0]     bpl_r, bpl_nxt;
  logic [LW-1:0]     ml_r, ml_nxt;
  logic [POS_W-1:0]  tp_r, tp_nxt;
  logic              done_r, done_nxt;

  logic [LW-1:0]     start_k;
  logic [LW-1:0]     rd_k;
  logic [LW-1:0]     rd_km1;
  logic              hit;
  logic              fall;
  logic [LW-1:0]     kfin;
  logic [POS_W-1:0]  tp_inc;

  assign hit    = (rd_pat == byte_r);
  assign fall   = (k_r != '0) && !hit;
  assign kfin   = hit ? (k_r + LW'(1)) : k_r;
  assign tp_inc = tp_r + POS_W'(1);

  // starting prefix length of a new request, after the restart rules
  always_comb begin
    if (req_op == OP_PATTERN) begin
      start_k = req_first ? '0 : bpl_r;
    end else begin
      start_k = (req_first || (ml_r >= plen_r)) ? '0 : ml_r;
    end
  end

  assign rd_km1  = rd_k - LW'(1);
  assign rd_idx  = rd_k[AW-1:0];
  assign rd_fidx = rd_km1[AW-1:0];
  assign req_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    plen_nxt  = plen_r;
    bpl_nxt   = bpl_r;
    ml_nxt    = ml_r;
    tp_nxt    = tp_r;
    done_nxt  = done_r;
    rd_k      = k_r;
    res_fire  = 1'b0;
    res       = '{status: ST_OK, match_position: '0};
    wr_en     = 1'b0;
    wr_idx    = plen_r[AW-1:0];
    wr_pat    = byte_r;
    wr_fail   = kfin[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        rd_k = start_k;
        if (req_fire) begin
          k_nxt     = start_k;
          state_nxt = S_LOOK;
          if (req_op == OP_PATTERN) begin
            if (req_first) begin
              plen_nxt = '0;
              bpl_nxt  = '0;
            end
            tp_nxt   = '0;
            ml_nxt   = '0;
            done_nxt = 1'b0;
          end else if (req_first) begin
            tp_nxt   = '0;
            ml_nxt   = '0;
            done_nxt = 1'b0;
          end
        end
      end
      S_LOOK: begin
        if (op_r == OP_PATTERN) begin
          if (plen_r >= MAX_LEN) begin
            // drop the byte, pattern keeps its first MAX_PATTERN bytes
            if (out_room) begin
              res_fire   = 1'b1;
              res.status = ST_TOO_LONG;
              state_nxt  = S_IDLE;
            end
          end else if ((plen_r != '0) && fall) begin
            k_nxt = LW'(rd_fail);
            rd_k  = LW'(rd_fail);
          end else if (out_room) begin
            wr_en = 1'b1;
            if (plen_r == '0) begin
              wr_fail = '0;
              bpl_nxt = '0;
            end else begin
              bpl_nxt = kfin;
            end
            plen_nxt  = plen_r + LW'(1);
            res_fire  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          if (done_r || (plen_r == '0)) begin
            if (out_room) begin
              res_fire  = 1'b1;
              state_nxt = S_IDLE;
              if (!done_r) begin
                // empty pattern matches at once, byte not consumed
                res.status         = ST_MATCH;
                res.match_position = tp_r;
                done_nxt           = 1'b1;
              end
            end
          end else if (fall) begin
            k_nxt = LW'(rd_fail);
            rd_k  = LW'(rd_fail);
          end else if (out_room) begin
            tp_nxt    = tp_inc;
            res_fire  = 1'b1;
            state_nxt = S_IDLE;
            if (kfin >= plen_r) begin
              res.status         = ST_MATCH;
              res.match_position = tp_inc - POS_W'(plen_r);
              done_nxt           = 1'b1;
              ml_nxt             = '0;
            end else begin
              ml_nxt = kfin;
              if (last_r) begin
                res.status = ST_UNMATCHED;
                done_nxt   = 1'b1;
              end
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plen_r  <= '0;
      bpl_r   <= '0;
      ml_r    <= '0;
      tp_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      plen_r  <= plen_nxt;
      bpl_r   <= bpl_nxt;
      ml_r    <= ml_nxt;
      tp_r    <= tp_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (req_fire) begin
      op_r   <= req_op;
      byte_r <= req_byte;
      last_r <= req_last;
    end
  end

  // a link walk never leaves the stored part of the pattern
  a_k_in_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && plen_r != '0) |-> (k_r < plen_r))
    else $error("prefix length beyond stored pattern");

  a_ml_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ml_r == '0) || (ml_r < plen_r))
    else $error("matched length not below pattern length");

  a_bpl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bpl_r == '0) || (bpl_r < plen_r))
    else $error("build prefix length not below pattern length");

  a_write_commits: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (res_fire && state_r == S_LOOK && op_r == OP_PATTERN))
    else $error("table write outside a pattern commit");

endmodule
